// ===== rtl/core/sdba_pkg.sv =====
// slot directory bump allocator: shared types, codes and constants
// used by the directory cells, the controller, the top level, the checker and the bench
package sdba_pkg;

   localparam int unsigned SDBA_SLOT_COUNT = 64;
   localparam logic [15:0] SDBA_MEMORY_SIZE_RST = 16'd1024;
   localparam logic [7:0]  SDBA_RAW_LIMIT_RST = 8'd255;
   localparam logic [7:0]  DECODED_LEN = 8'd7;

   // end addresses and high-water mark carry one spare bit
   localparam int unsigned HW_W = 17;
   localparam int unsigned SUM_W = HW_W + 1;

   typedef enum logic [1:0] {
      CMD_STORE  = 2'd0,
      CMD_FETCH  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_FORMAT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_EMPTY   = 2'd0,
      KIND_DECODED = 2'd1,
      KIND_RAW     = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_BAD_SLOT = 3'd1,
      STS_EMPTY    = 3'd2,
      STS_FULL     = 3'd3,
      STS_UNUSED   = 3'd4,
      STS_BAD_LEN  = 3'd5
   } status_type;

   typedef enum logic {
      CSR_MEMORY_SIZE = 1'b0,
      CSR_RAW_LIMIT   = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic        used;
      logic        raw;
      logic [7:0]  length;
      logic [15:0] start;
   } entry_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic            valid;
      logic [HW_W-1:0] hw;
      logic [HW_W-1:0] hw_excl;
      entry_type       hit;
   } token_type;

   // directory write broadcast from the controller
   typedef struct packed {
      logic       fmt;
      logic       wen;
      logic [7:0] slot;
      entry_type  entry;
   } wr_type;

endpackage

// ===== rtl/core/sdba_if.sv =====
// slot directory bump allocator: request, response and register write channels
// plain valid/ready channels, no dependencies
interface sdba_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] slot;
   logic [1:0] signal_kind;
   logic [7:0] raw_length;

   modport source (output valid, cmd, slot, signal_kind, raw_length, input ready);
   modport sink (input valid, cmd, slot, signal_kind, raw_length, output ready);
endinterface

interface sdba_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [2:0]  status;
   logic [15:0] payload_addr;
   logic [7:0]  payload_len;
   logic        is_raw;
   logic [15:0] free_bytes;

   modport source (output valid, ok, status, payload_addr, payload_len, is_raw, free_bytes,
                   input ready);
   modport sink (input valid, ok, status, payload_addr, payload_len, is_raw, free_bytes,
                 output ready);
endinterface

interface sdba_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sdba_cell.sv =====
// slot directory bump allocator: one directory cell
// holds one slot entry and folds it into the scan token passing by; uses sdba_pkg
module sdba_cell import sdba_pkg::*; #(
   parameter int unsigned IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic [7:0] scan_slot,
   input  wr_type    wr,
   input  token_type prev_tok,
   output token_type next_tok
);

   entry_type entry_ff, entry_in;
   token_type tok_ff, tok_in;
   logic [HW_W-1:0] end_addr;
   logic here;

   assign here = (scan_slot == 8'(IDX));
   assign end_addr = HW_W'(entry_ff.start) + HW_W'(entry_ff.length);

   always_comb begin
      tok_in.valid = prev_tok.valid;
      tok_in.hw = (entry_ff.used && end_addr > prev_tok.hw) ? end_addr : prev_tok.hw;
      // high-water mark as it would be without this request's own slot
      tok_in.hw_excl = (entry_ff.used && !here && end_addr > prev_tok.hw_excl) ?
                       end_addr : prev_tok.hw_excl;
      tok_in.hit = here ? entry_ff : prev_tok.hit;
   end

   always_comb begin
      entry_in = entry_ff;
      if (wr.fmt) begin
         entry_in = '0;
      end else if (wr.wen && wr.slot == 8'(IDX)) begin
         entry_in = wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         tok_ff <= tok_in;
      end
   end

   assign next_tok = tok_ff;

endmodule

// ===== rtl/core/sdba_ctrl.sv =====
// slot directory bump allocator: request sequencer, decision logic and registers
// launches the scan token, applies the command when it returns; uses sdba_pkg, sdba_if
module sdba_ctrl import sdba_pkg::*; #(
   parameter int unsigned SLOT_COUNT = SDBA_SLOT_COUNT
) (
   input  logic          clock,
   input  logic          reset,
   sdba_req_if.sink      req,
   sdba_rsp_if.source    rsp,
   sdba_csr_if.sink      csr,
   output token_type     launch_tok,
   input  token_type     last_tok,
   output logic [7:0]    scan_slot,
   output wr_type        wr
);

   typedef enum logic [1:0] {IDLE, SCAN, RESPOND} state_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  status;
      logic [15:0] addr;
      logic [7:0]  len;
      logic        raw;
      logic [15:0] free;
   } result_type;

   state_type   state_ff, state_in;
   logic        launch_ff, launch_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [7:0]  slot_ff, slot_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  rlen_ff, rlen_in;
   logic [15:0] mem_size_ff, mem_size_in;
   logic [7:0]  raw_limit_ff, raw_limit_in;
   result_type  pend_ff, pend_in;
   result_type  rsp_ff, rsp_in;

   status_type      st;
   logic [7:0]      want;
   logic            want_raw;
   logic            reuse;
   logic [15:0]     off;
   logic [SUM_W-1:0] sum;
   logic [HW_W-1:0] hw_new;
   logic [HW_W-1:0] mem_ext;
   result_type      res;
   wr_type          wr_d;

   assign mem_ext = HW_W'(mem_size_ff);

   // command decision once the token has seen every cell
   always_comb begin
      st = STS_OK;
      want = '0;
      want_raw = 1'b0;
      reuse = 1'b0;
      off = '0;
      sum = '0;
      hw_new = last_tok.hw;
      wr_d = '0;
      wr_d.slot = slot_ff;
      res = '0;
      if (cmd_ff == CMD_FORMAT) begin
         wr_d.fmt = 1'b1;
         hw_new = '0;
      end else if (slot_ff >= 8'(SLOT_COUNT)) begin
         st = STS_BAD_SLOT;
      end else begin
         case (cmd_ff)
            CMD_CLEAR: begin
               wr_d.wen = 1'b1;
               hw_new = last_tok.hw_excl;
            end
            CMD_FETCH: begin
               if (!last_tok.hit.used) begin
                  st = STS_UNUSED;
               end else if (last_tok.hit.raw) begin
                  if (last_tok.hit.length == 8'd0 || last_tok.hit.length > raw_limit_ff) begin
                     st = STS_BAD_LEN;
                  end
               end else if (last_tok.hit.length != DECODED_LEN) begin
                  st = STS_BAD_LEN;
               end
               if (st == STS_OK) begin
                  res.addr = last_tok.hit.start;
                  res.len = last_tok.hit.length;
                  res.raw = last_tok.hit.raw;
               end
            end
            CMD_STORE: begin
               if (kind_ff == KIND_DECODED) begin
                  want = DECODED_LEN;
               end else if (kind_ff == KIND_RAW && rlen_ff != 8'd0) begin
                  want = rlen_ff;
                  want_raw = 1'b1;
               end else begin
                  st = STS_EMPTY;
               end
               if (st == STS_OK) begin
                  reuse = last_tok.hit.used && last_tok.hit.length == want;
                  sum = SUM_W'(last_tok.hw) + SUM_W'(want);
                  off = reuse ? last_tok.hit.start : last_tok.hw[15:0];
                  if (!reuse && sum > SUM_W'(mem_size_ff)) begin
                     st = STS_FULL;
                  end
               end
               if (st == STS_OK) begin
                  wr_d.wen = 1'b1;
                  wr_d.entry.used = 1'b1;
                  wr_d.entry.raw = want_raw;
                  wr_d.entry.length = want;
                  wr_d.entry.start = off;
                  res.addr = off;
                  res.len = want;
                  res.raw = want_raw;
                  // a fresh placement sits on top of everything else
                  hw_new = reuse ? last_tok.hw : sum[HW_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
      res.ok = (st == STS_OK);
      res.status = st;
      res.free = (mem_ext > hw_new) ? 16'(mem_ext - hw_new) : 16'd0;
   end

   always_comb begin
      state_in = state_ff;
      launch_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      cmd_in = cmd_ff;
      slot_in = slot_ff;
      kind_in = kind_ff;
      rlen_in = rlen_ff;
      mem_size_in = mem_size_ff;
      raw_limit_in = raw_limit_ff;
      pend_in = pend_ff;
      rsp_in = rsp_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr.valid) begin
         unique case (csr_idx_type'(csr.index))
            CSR_MEMORY_SIZE: mem_size_in = csr.data;
            CSR_RAW_LIMIT:   raw_limit_in = csr.data[7:0];
         endcase
      end

      unique case (state_ff)
         IDLE: begin
            if (req.valid) begin
               cmd_in = req.cmd;
               slot_in = req.slot;
               kind_in = req.signal_kind;
               rlen_in = req.raw_length;
               launch_in = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (last_tok.valid) begin
               pend_in = res;
               state_in = RESPOND;
            end
         end
         RESPOND: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_in = pend_ff;
               rsp_valid_in = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         launch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mem_size_ff <= SDBA_MEMORY_SIZE_RST;
         raw_limit_ff <= SDBA_RAW_LIMIT_RST;
      end else begin
         state_ff <= state_in;
         launch_ff <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         mem_size_ff <= mem_size_in;
         raw_limit_ff <= raw_limit_in;
         cmd_ff <= cmd_in;
         slot_ff <= slot_in;
         kind_ff <= kind_in;
         rlen_ff <= rlen_in;
         pend_ff <= pend_in;
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      wr = wr_d;
      if (!(state_ff == SCAN && last_tok.valid)) begin
         wr.wen = 1'b0;
         wr.fmt = 1'b0;
      end
   end

   always_comb begin
      launch_tok = '0;
      launch_tok.valid = launch_ff;
   end

   assign scan_slot = slot_ff;
   assign req.ready = (state_ff == IDLE);
   assign csr.ready = 1'b1;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.ok = rsp_ff.ok;
   assign rsp.status = rsp_ff.status;
   assign rsp.payload_addr = rsp_ff.addr;
   assign rsp.payload_len = rsp_ff.len;
   assign rsp.is_raw = rsp_ff.raw;
   assign rsp.free_bytes = rsp_ff.free;

endmodule

// ===== rtl/core/slot_directory_bump_allocator.sv =====
// Slot directory with a bump allocator. For each request (store, fetch, clear, format)
// a scan token walks the row of directory cells one cell per cycle, gathering the
// high-water mark and the addressed slot's entry, and the command is applied when it
// leaves the last cell. One request is in flight at a time; a finished response waits
// in its output register while the next request is taken. Register writes are taken
// every cycle and also affect a request whose scan is still running.
module slot_directory_bump_allocator import sdba_pkg::*; #(
   parameter int unsigned SLOT_COUNT = SDBA_SLOT_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   sdba_req_if.sink    req_ch,
   sdba_rsp_if.source  rsp_ch,
   sdba_csr_if.sink    csr_ch
);

   token_type  chain [0:SLOT_COUNT];
   logic [7:0] scan_slot;
   wr_type     wr;

   sdba_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .launch_tok (chain[0]),
      .last_tok   (chain[SLOT_COUNT]),
      .scan_slot  (scan_slot),
      .wr         (wr)
   );

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      sdba_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .scan_slot (scan_slot),
         .wr        (wr),
         .prev_tok  (chain[i]),
         .next_tok  (chain[i+1])
      );
   end

endmodule

// ===== rtl/core/sdba_checker.sv =====
// slot directory bump allocator: port-level checker and its bind
// sees only the top-level channels; uses sdba_pkg
module sdba_checker import sdba_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_payload_addr,
   input logic [7:0]  rsp_payload_len,
   input logic        rsp_is_raw,
   input logic [15:0] rsp_free_bytes
);

   // a held response does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_payload_addr)
         && $stable(rsp_payload_len) && $stable(rsp_is_raw) && $stable(rsp_free_bytes))
      else $error("response changed while stalled");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ok == (rsp_status == STS_OK)))
      else $error("ok flag disagrees with status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_payload_addr == 16'd0 && rsp_payload_len == 8'd0
         && !rsp_is_raw)
      else $error("failed response carries payload fields");

   // decoded payloads are always seven bytes
   a_decoded_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok && !rsp_is_raw && rsp_payload_len != 8'd0
         |-> rsp_payload_len == DECODED_LEN)
      else $error("decoded payload with wrong length");

endmodule

bind slot_directory_bump_allocator sdba_checker u_sdba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_ok           (rsp_ch.ok),
   .rsp_status       (rsp_ch.status),
   .rsp_payload_addr (rsp_ch.payload_addr),
   .rsp_payload_len  (rsp_ch.payload_len),
   .rsp_is_raw       (rsp_ch.is_raw),
   .rsp_free_bytes   (rsp_ch.free_bytes)
);

// ===== dv/slot_directory_bump_allocator_tb.sv =====
// testbench for slot_directory_bump_allocator: directed and random requests checked
// against a directory and high-water model kept in the bench
// depends on sdba_pkg and the channel interfaces in sdba_if
module slot_directory_bump_allocator_tb;
   import sdba_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE_CYCLES = 70;
   localparam int unsigned RANDOM_REQUESTS = 950;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned RSP_HOLD_CYCLES = 400;
   localparam int unsigned MAX_REPORTS = 10;
   // signal kind code with no name of its own, handled as an empty signal
   localparam logic [1:0] KIND_UNDEFINED = 2'd3;

   typedef struct packed {
      logic        ok;
      status_type  status;
      logic [15:0] payload_addr;
      logic [7:0]  payload_len;
      logic        is_raw;
      logic [15:0] free_bytes;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdba_req_if req_ch ();
   sdba_rsp_if rsp_ch ();
   sdba_csr_if csr_ch ();

   slot_directory_bump_allocator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // bench copy of the directory and registers
   logic        slot_used  [SDBA_SLOT_COUNT];
   logic        slot_raw   [SDBA_SLOT_COUNT];
   logic [7:0]  slot_len   [SDBA_SLOT_COUNT];
   logic [15:0] slot_start [SDBA_SLOT_COUNT];
   logic [15:0] memory_size;
   logic [7:0]  raw_limit;

   answer_type  awaited_answers[$];

   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;
   int unsigned answers_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned stray_count = 0;
   int unsigned status_tally [6];

   bit          sender_gaps_on = 1'b1;
   bit          receiver_stalls_on = 1'b1;
   bit          hold_toggle = 1'b0;
   bit          hold_seen = 1'b0;
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_hold_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void wipe_directory();
      for (int s = 0; s < SDBA_SLOT_COUNT; s++) begin
         slot_used[s] = 1'b0;
         slot_raw[s] = 1'b0;
         slot_len[s] = '0;
         slot_start[s] = '0;
      end
   endfunction

   function automatic int unsigned high_water_mark();
      int unsigned top;
      top = 0;
      for (int s = 0; s < SDBA_SLOT_COUNT; s++) begin
         if (slot_used[s] && slot_start[s] + slot_len[s] > top)
            top = slot_start[s] + slot_len[s];
      end
      return top;
   endfunction

   function automatic answer_type predict_allocation(cmd_type cmd, logic [7:0] slot,
                                                     logic [1:0] kind, logic [7:0] raw_len);
      answer_type  ans;
      int unsigned want;
      int unsigned offset;
      int unsigned top;
      logic        want_raw;
      ans = '0;
      ans.status = STS_OK;
      want = 0;
      want_raw = 1'b0;
      offset = 0;
      if (cmd == CMD_FORMAT) begin
         wipe_directory();
      end else if (slot >= SDBA_SLOT_COUNT) begin
         ans.status = STS_BAD_SLOT;
      end else if (cmd == CMD_CLEAR) begin
         slot_used[slot] = 1'b0;
         slot_raw[slot] = 1'b0;
         slot_len[slot] = '0;
         slot_start[slot] = '0;
      end else if (cmd == CMD_FETCH) begin
         if (!slot_used[slot])
            ans.status = STS_UNUSED;
         else if (slot_raw[slot]) begin
            if (slot_len[slot] == 0 || slot_len[slot] > raw_limit)
               ans.status = STS_BAD_LEN;
         end else if (slot_len[slot] != DECODED_LEN)
            ans.status = STS_BAD_LEN;
         if (ans.status == STS_OK) begin
            ans.payload_addr = slot_start[slot];
            ans.payload_len = slot_len[slot];
            ans.is_raw = slot_raw[slot];
         end
      end else begin
         if (kind == KIND_DECODED)
            want = DECODED_LEN;
         else if (kind == KIND_RAW && raw_len != 0) begin
            want = raw_len;
            want_raw = 1'b1;
         end else
            ans.status = STS_EMPTY;
         if (ans.status == STS_OK) begin
            // same length in a used slot keeps its place, no size check
            if (slot_used[slot] && slot_len[slot] == want)
               offset = slot_start[slot];
            else begin
               offset = high_water_mark();
               if (offset + want > memory_size) ans.status = STS_FULL;
            end
            if (ans.status == STS_OK) begin
               slot_used[slot] = 1'b1;
               slot_raw[slot] = want_raw;
               slot_len[slot] = want[7:0];
               slot_start[slot] = offset[15:0];
               ans.payload_addr = offset[15:0];
               ans.payload_len = want[7:0];
               ans.is_raw = want_raw;
            end
         end
      end
      ans.ok = (ans.status == STS_OK);
      top = high_water_mark();
      ans.free_bytes = (memory_size > top) ? 16'(memory_size - top) : 16'd0;
      return ans;
   endfunction

   // mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver side: random stalls plus an on-demand long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         rsp_hold_left <= RSP_HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (receiver_stalls_on && $urandom_range(0, 99) < 15) begin
         rsp_stall_left <= pick_gap();
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      answer_type got;
      answer_type wanted;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.ok = rsp_ch.ok;
         got.status = status_type'(rsp_ch.status);
         got.payload_addr = rsp_ch.payload_addr;
         got.payload_len = rsp_ch.payload_len;
         got.is_raw = rsp_ch.is_raw;
         got.free_bytes = rsp_ch.free_bytes;
         answers_seen++;
         if (rsp_ch.status < 6) status_tally[rsp_ch.status]++;
         if (awaited_answers.size() == 0) begin
            stray_count++;
            if (stray_count + mismatch_count <= MAX_REPORTS)
               $display("response %0d arrived with no request outstanding", answers_seen);
         end else begin
            wanted = awaited_answers.pop_front();
            if (got !== wanted) begin
               mismatch_count++;
               if (stray_count + mismatch_count <= MAX_REPORTS) begin
                  $write("response %0d: expected ok=%0d status=%0d addr=%0d len=%0d raw=%0d",
                         answers_seen, wanted.ok, wanted.status, wanted.payload_addr,
                         wanted.payload_len, wanted.is_raw);
                  $display(" free=%0d, got ok=%0d status=%0d addr=%0d len=%0d raw=%0d free=%0d",
                           wanted.free_bytes, got.ok, got.status, got.payload_addr,
                           got.payload_len, got.is_raw, got.free_bytes);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d requests still outstanding", cycle_count,
                  awaited_answers.size());
         $display("slot_directory_bump_allocator_tb NOT OK");
         $finish;
      end
   end

   // called at a clock edge; returns at the edge where the request is taken
   task automatic send_request(cmd_type cmd, logic [7:0] slot, logic [1:0] kind,
                               logic [7:0] raw_len);
      int unsigned gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.slot <= slot;
      req_ch.signal_kind <= kind;
      req_ch.raw_length <= raw_len;
      do @(posedge clock); while (!req_ch.ready);
      awaited_answers.push_back(predict_allocation(cmd, slot, kind, raw_len));
      requests_sent++;
   endtask

   task automatic wait_until_drained(int unsigned tail);
      req_ch.valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_register(csr_idx_type idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_MEMORY_SIZE)
         memory_size = value;
      else
         raw_limit = value[7:0];
      @(posedge clock);
   endtask

   task automatic set_registers(logic [15:0] mem_bytes, logic [7:0] limit);
      wait_until_drained(2);
      write_register(CSR_MEMORY_SIZE, mem_bytes);
      write_register(CSR_RAW_LIMIT, {8'd0, limit});
   endtask

   task automatic test_directed_basics();
      send_request(CMD_FORMAT, 8'd0, KIND_EMPTY, 8'd0);
      send_request(CMD_FETCH, 8'd0, KIND_EMPTY, 8'd0);
      send_request(CMD_STORE, 8'd0, KIND_EMPTY, 8'd255);
      send_request(CMD_STORE, 8'd0, KIND_UNDEFINED, 8'd255);
      send_request(CMD_STORE, 8'd0, KIND_RAW, 8'd0);
      send_request(CMD_STORE, 8'd0, KIND_DECODED, 8'd0);
      send_request(CMD_STORE, 8'd63, KIND_RAW, 8'd255);
      send_request(CMD_FETCH, 8'd0, KIND_EMPTY, 8'd0);
      send_request(CMD_FETCH, 8'd63, KIND_EMPTY, 8'd0);
      // same length again stays in place
      send_request(CMD_STORE, 8'd63, KIND_RAW, 8'd255);
      send_request(CMD_STORE, 8'd0, KIND_DECODED, 8'd255);
      send_request(CMD_STORE, 8'd63, KIND_RAW, 8'd254);
      send_request(CMD_STORE, 8'd64, KIND_DECODED, 8'd0);
      send_request(CMD_FETCH, 8'd255, KIND_UNDEFINED, 8'd255);
      send_request(CMD_CLEAR, 8'd128, KIND_RAW, 8'd1);
      send_request(CMD_CLEAR, 8'd5, KIND_EMPTY, 8'd0);
      send_request(CMD_CLEAR, 8'd63, KIND_EMPTY, 8'd0);
      send_request(CMD_FETCH, 8'd63, KIND_EMPTY, 8'd0);
      send_request(CMD_STORE, 8'd1, KIND_RAW, 8'd1);
      send_request(CMD_FORMAT, 8'd255, KIND_UNDEFINED, 8'd255);
      send_request(CMD_FETCH, 8'd1, KIND_EMPTY, 8'd0);
   endtask

   task automatic test_store_limits();
      set_registers(16'd20, 8'd255);
      send_request(CMD_STORE, 8'd0, KIND_DECODED, 8'd0);
      send_request(CMD_STORE, 8'd1, KIND_DECODED, 8'd0);
      send_request(CMD_STORE, 8'd2, KIND_DECODED, 8'd0);
      send_request(CMD_STORE, 8'd3, KIND_RAW, 8'd6);
      send_request(CMD_STORE, 8'd4, KIND_RAW, 8'd1);
      // memory shrunk below the high-water mark
      set_registers(16'd10, 8'd255);
      send_request(CMD_FETCH, 8'd3, KIND_EMPTY, 8'd0);
      send_request(CMD_STORE, 8'd3, KIND_RAW, 8'd6);
      send_request(CMD_STORE, 8'd1, KIND_RAW, 8'd7);
      send_request(CMD_FETCH, 8'd1, KIND_EMPTY, 8'd0);
      set_registers(16'd0, 8'd255);
      send_request(CMD_FORMAT, 8'd0, KIND_EMPTY, 8'd0);
      send_request(CMD_STORE, 8'd0, KIND_RAW, 8'd1);
      send_request(CMD_STORE, 8'd0, KIND_DECODED, 8'd0);
      send_request(CMD_FETCH, 8'd0, KIND_EMPTY, 8'd0);
      set_registers(16'd65535, 8'd100);
      send_request(CMD_STORE, 8'd10, KIND_RAW, 8'd200);
      send_request(CMD_FETCH, 8'd10, KIND_EMPTY, 8'd0);
      send_request(CMD_STORE, 8'd11, KIND_RAW, 8'd100);
      send_request(CMD_FETCH, 8'd11, KIND_EMPTY, 8'd0);
      set_registers(16'd65535, 8'd1);
      send_request(CMD_STORE, 8'd12, KIND_RAW, 8'd1);
      send_request(CMD_FETCH, 8'd12, KIND_EMPTY, 8'd0);
      send_request(CMD_FETCH, 8'd11, KIND_EMPTY, 8'd0);
      set_registers(16'd65535, 8'd255);
      send_request(CMD_FETCH, 8'd10, KIND_EMPTY, 8'd0);
   endtask

   task automatic test_response_backpressure();
      set_registers(16'd4096, 8'd255);
      sender_gaps_on = 1'b0;
      receiver_stalls_on = 1'b0;
      hold_toggle = ~hold_toggle;
      // input stalls once the output register and the request in flight are both full
      for (int i = 0; i < 12; i++)
         send_request(CMD_STORE, 8'(i * 5), (i % 2 == 1) ? KIND_RAW : KIND_DECODED,
                      8'(i * 20 + 1));
      wait_until_drained(SETTLE_CYCLES);
   endtask

   task automatic send_random_request();
      int unsigned roll;
      cmd_type     cmd;
      logic [7:0]  slot;
      logic [1:0]  kind;
      logic [7:0]  raw_len;
      roll = $urandom_range(0, 99);
      if (roll < 50) cmd = CMD_STORE;
      else if (roll < 75) cmd = CMD_FETCH;
      else if (roll < 96) cmd = CMD_CLEAR;
      else cmd = CMD_FORMAT;
      slot = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(64, 255))
                                          : 8'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (roll < 40) kind = KIND_DECODED;
      else if (roll < 85) kind = KIND_RAW;
      else kind = 2'($urandom_range(0, 3));
      // short lengths make in-place reuse likely
      roll = $urandom_range(0, 99);
      if (roll < 30) raw_len = 8'($urandom_range(1, 8));
      else if (roll < 92) raw_len = 8'($urandom_range(1, 255));
      else raw_len = 8'd0;
      send_request(cmd, slot, kind, raw_len);
   endtask

   task automatic test_random_traffic();
      logic [15:0] mem_bytes;
      logic [7:0]  limit;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: mem_bytes = SDBA_MEMORY_SIZE_RST;
            1: mem_bytes = 16'($urandom_range(30, 400));
            2: mem_bytes = 16'd65535;
            3: mem_bytes = 16'($urandom_range(0, 65535));
            4: mem_bytes = 16'($urandom_range(1000, 4000));
            5: mem_bytes = 16'($urandom_range(0, 60));
            6: mem_bytes = 16'($urandom_range(200, 2000));
            default: mem_bytes = SDBA_MEMORY_SIZE_RST;
         endcase
         case (phase % 3)
            0: limit = SDBA_RAW_LIMIT_RST;
            1: limit = 8'($urandom_range(1, 255));
            default: limit = 8'd1;
         endcase
         set_registers(mem_bytes, limit);
         sender_gaps_on = (phase != 2 && phase != 6);
         receiver_stalls_on = (phase != 4 && phase != 6);
         for (int n = 0; n < RANDOM_REQUESTS / RANDOM_PHASES; n++)
            send_random_request();
      end
   endtask

   initial begin
      wipe_directory();
      memory_size = SDBA_MEMORY_SIZE_RST;
      raw_limit = SDBA_RAW_LIMIT_RST;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_STORE;
      req_ch.slot = '0;
      req_ch.signal_kind = KIND_EMPTY;
      req_ch.raw_length = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_MEMORY_SIZE;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basics();
      test_store_limits();
      test_response_backpressure();
      sender_gaps_on = 1'b1;
      receiver_stalls_on = 1'b1;
      test_random_traffic();
      wait_until_drained(SETTLE_CYCLES);

      $display("%0d requests, %0d responses: %0d ok, %0d bad slot, %0d empty signal,",
               requests_sent, answers_seen, status_tally[STS_OK], status_tally[STS_BAD_SLOT],
               status_tally[STS_EMPTY]);
      $display("  %0d store full, %0d slot unused, %0d bad length, %0d cycles",
               status_tally[STS_FULL], status_tally[STS_UNUSED], status_tally[STS_BAD_LEN],
               cycle_count);
      if (mismatch_count == 0 && stray_count == 0 && awaited_answers.size() == 0)
         $display("slot_directory_bump_allocator_tb OK");
      else
         $display("slot_directory_bump_allocator_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/sdba_pkg.sv
rtl/core/sdba_if.sv
rtl/core/sdba_cell.sv
rtl/core/sdba_ctrl.sv
rtl/core/slot_directory_bump_allocator.sv
rtl/core/sdba_checker.sv
dv/slot_directory_bump_allocator_tb.sv
